// ===== design/sha256_pkg.sv =====
// Package for the SHA-256 byte stream hasher: command type, round constants,
// initial hash values and round helper functions. No dependencies.
package sha256_pkg;

    localparam logic [1:0] CMD_BYTE     = 2'd0;
    localparam logic [1:0] CMD_END      = 2'd1;
    localparam logic [1:0] CMD_BYTE_END = 2'd2;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
    } cmd_t;

    localparam logic [31:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RC [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int s);
        rotr = (x >> s) | (x << (32 - s));
    endfunction

    function automatic logic [31:0] ssig0(input logic [31:0] x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] ssig1(input logic [31:0] x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(input logic [31:0] x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(input logic [31:0] x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

endpackage

// ===== design/sha256_front.sv =====
// Front end: accepts input beats, classifies them into commands and queues them.
// Depends on sha256_pkg.
module sha256_front #(
    parameter int QDEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          data_byte,
    input  logic                has_byte,
    input  logic                end_of_message,
    input  logic                in_valid,
    output logic                in_ready,
    output sha256_pkg::cmd_t    cmd,
    output logic                cmd_valid,
    input  logic                cmd_ready
);
    localparam int AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    sha256_pkg::cmd_t  q_reg [QDEPTH];
    logic [AW-1:0]     wr_reg, rd_reg;
    logic [AW:0]       cnt_reg;
    sha256_pkg::cmd_t  c;
    logic              push, pop, useful;

    always_comb
    begin
        c.data = data_byte;
        c.cmd  = sha256_pkg::CMD_BYTE;
        if (has_byte && end_of_message)
            c.cmd = sha256_pkg::CMD_BYTE_END;
        else if (end_of_message)
            c.cmd = sha256_pkg::CMD_END;
    end

    assign useful    = has_byte | end_of_message;
    assign in_ready  = (cnt_reg != (AW+1)'(QDEPTH));
    assign push      = in_valid && in_ready && useful;
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_reg];
    assign pop       = cmd_valid && cmd_ready;

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= (wr_reg == AW'(QDEPTH - 1)) ? '0 : wr_reg + 1'b1;
            if (pop)
                rd_reg <= (rd_reg == AW'(QDEPTH - 1)) ? '0 : rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end
endmodule

// ===== design/sha256_core.sv =====
// Back end: block buffer, padding, 64-round compression and digest output.
// Depends on sha256_pkg.
module sha256_core (
    input  logic                clk,
    input  logic                rst_n,
    input  sha256_pkg::cmd_t    cmd,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    output logic [31:0]         digest_word,
    output logic [2:0]          word_number,
    output logic                last_word,
    output logic                out_valid,
    input  logic                out_ready
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]   st_reg, st_next;
    logic [31:0]  w_reg [16];      // 16-word message window, word 0 = current
    logic [31:0]  v_reg [8];
    logic [31:0]  h_reg [8];
    logic [5:0]   cnt_reg;         // bytes in block, then round index
    logic [63:0]  bits_reg;
    logic [63:0]  total_reg;
    logic [5:0]   pos_reg;         // pad write position
    logic         fin_reg;         // padding running
    logic         lenblk_reg;      // current pad block holds the length
    logic         mark_due_reg;    // end came on a full block, marker still owed
    logic [2:0]   oidx_reg;

    logic [31:0]  t1, t2, wn;
    logic [3:0]   wi;
    logic [1:0]   bi;
    logic [7:0]   pad_byte;
    logic         take;

    assign cmd_ready = (st_reg == S_IDLE);
    assign take      = cmd_valid && cmd_ready;
    assign out_valid = (st_reg == S_OUT);
    assign digest_word = h_reg[oidx_reg];
    assign word_number = oidx_reg;
    assign last_word   = (oidx_reg == 3'd7);

    always_comb
    begin
        t1 = v_reg[7] + sha256_pkg::bsig1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha256_pkg::RC[cnt_reg] + w_reg[0];
        t2 = sha256_pkg::bsig0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        wn = w_reg[0] + sha256_pkg::ssig0(w_reg[1]) + w_reg[9]
           + sha256_pkg::ssig1(w_reg[14]);
        wi = pos_reg[5:2];
        bi = pos_reg[1:0];
        if (pos_reg == cnt_reg && !lenblk_reg)
            pad_byte = 8'h80;
        else if (lenblk_reg && pos_reg >= 6'd56)
            pad_byte = total_reg[8*(7 - (pos_reg - 6'd56)) +: 8];
        else
            pad_byte = 8'h00;
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    if (cmd.cmd == sha256_pkg::CMD_BYTE && cnt_reg == 6'd63)
                        st_next = S_ROUND;
                    else if (cmd.cmd == sha256_pkg::CMD_BYTE_END && cnt_reg == 6'd63)
                        st_next = S_ROUND;
                    else if (cmd.cmd != sha256_pkg::CMD_BYTE)
                        st_next = S_PAD;
                end
            end
            S_PAD:   if (pos_reg == 6'd63) st_next = S_ROUND;
            S_ROUND: if (cnt_reg == 6'd63) st_next = S_ADD;
            S_ADD:   st_next = (fin_reg && lenblk_reg) ? S_OUT
                             : (fin_reg ? S_PAD : S_IDLE);
            S_OUT:   if (out_ready && oidx_reg == 3'd7) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (take && cmd.cmd != sha256_pkg::CMD_END)
            w_reg[cnt_reg[5:2]][8*(3 - cnt_reg[1:0]) +: 8] <= cmd.data;
        else if (st_reg == S_PAD)
            w_reg[wi][8*(3 - bi) +: 8] <= pad_byte;
        else if (st_reg == S_ROUND)
        begin
            for (int k = 0; k < 15; k++)
                w_reg[k] <= w_reg[k+1];
            w_reg[15] <= wn;
        end
        if (st_reg == S_ROUND)
        begin
            v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        else
            v_reg <= h_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= S_IDLE;
            h_reg        <= sha256_pkg::IV;
            cnt_reg      <= '0;
            bits_reg     <= '0;
            total_reg    <= '0;
            pos_reg      <= '0;
            fin_reg      <= 1'b0;
            lenblk_reg   <= 1'b0;
            mark_due_reg <= 1'b0;
            oidx_reg     <= '0;
        end
        else
        begin
            st_reg <= st_next;
            case (st_reg)
                S_IDLE:
                begin
                    if (take)
                    begin
                        if (cmd.cmd != sha256_pkg::CMD_END)
                            cnt_reg <= cnt_reg + 1'b1;
                        if (cmd.cmd != sha256_pkg::CMD_BYTE)
                        begin
                            fin_reg <= 1'b1;
                            if (cmd.cmd == sha256_pkg::CMD_BYTE_END && cnt_reg == 6'd63)
                            begin
                                // full block first, then padding from byte 0
                                total_reg    <= bits_reg + 64'd512;
                                lenblk_reg   <= 1'b0;
                                mark_due_reg <= 1'b1;
                                pos_reg      <= 6'd0;
                            end
                            else
                            begin
                                if (cmd.cmd == sha256_pkg::CMD_BYTE_END)
                                begin
                                    total_reg <= bits_reg + {55'd0, cnt_reg + 6'd1, 3'd0};
                                    pos_reg   <= cnt_reg + 6'd1;
                                end
                                else
                                begin
                                    total_reg <= bits_reg + {55'd0, cnt_reg, 3'd0};
                                    pos_reg   <= cnt_reg;
                                end
                                lenblk_reg <= 1'b0;
                            end
                        end
                        if (cmd.cmd == sha256_pkg::CMD_BYTE_END)
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_PAD:
                begin
                    pos_reg <= pos_reg + 1'b1;
                    // pos after the marker byte of the first pad block
                    if (pos_reg == cnt_reg && !lenblk_reg && pos_reg < 6'd56)
                        lenblk_reg <= 1'b1;
                    if (pos_reg == 6'd63)
                        cnt_reg <= '0;
                end
                S_ROUND:
                    cnt_reg <= cnt_reg + 1'b1;
                S_ADD:
                begin
                    for (int k = 0; k < 8; k++)
                        h_reg[k] <= h_reg[k] + v_reg[k];
                    if (!fin_reg)
                        bits_reg <= bits_reg + 64'd512;
                    pos_reg <= '0;
                    if (fin_reg && !lenblk_reg && !mark_due_reg)
                    begin
                        // marker went into the previous block; next block
                        // starts with zeros, marker slot disabled
                        cnt_reg    <= 6'd63;
                        lenblk_reg <= 1'b1;
                    end
                    else
                        cnt_reg <= '0;
                    mark_due_reg <= 1'b0;
                    oidx_reg     <= '0;
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        oidx_reg <= oidx_reg + 1'b1;
                        if (oidx_reg == 3'd7)
                        begin
                            h_reg      <= sha256_pkg::IV;
                            bits_reg   <= '0;
                            cnt_reg    <= '0;
                            fin_reg    <= 1'b0;
                            lenblk_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== design/sha256_byte_stream_hasher_unit.sv =====
// Top level of the SHA-256 byte stream hasher: front queue plus compression core.
// Depends on sha256_pkg, sha256_front and sha256_core.
//
// Computes standard SHA-256 over a byte stream. Each beat carries an optional
// byte (has_byte) and an end-of-message flag. A beat with neither is dropped
// at once. Beats land in a short command queue, so the input keeps accepting
// while the core compresses, until the queue is full. The core takes bytes only
// while idle; the 64th of a block also starts a compression of 64 rounds and
// then the hash update, and no further bytes are taken until both are done.
// End of message runs a padding fill of one cycle per byte from the marker
// position to the end of the block and one compression; a second pad block
// (a full 64-byte fill plus a compression) follows when fewer than 9 bytes
// remain free for the marker and length. An end beat whose byte fills
// a block compresses that block first and then pads a fresh one. The eight
// digest words are then offered one per cycle while out_ready is high, word 0
// first, last_word on word 7. The running hash then returns to the initial
// values for the next message.
module sha256_byte_stream_hasher_unit #(
    parameter int QDEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    input  logic        in_valid,
    output logic        in_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_number,
    output logic        last_word,
    output logic        out_valid,
    input  logic        out_ready
);
    sha256_pkg::cmd_t cmd;
    logic             cmd_valid, cmd_ready;

    sha256_front #(.QDEPTH(QDEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .data_byte(data_byte), .has_byte(has_byte), .end_of_message(end_of_message),
        .in_valid(in_valid), .in_ready(in_ready),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
    );

    sha256_core u_core (
        .clk(clk), .rst_n(rst_n),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .digest_word(digest_word), .word_number(word_number), .last_word(last_word),
        .out_valid(out_valid), .out_ready(out_ready)
    );
endmodule
